/* rtl/core/bgba_pkg.sv */
// ----------------------------------------------------------------------------
// bgba_pkg: shared types and constants for the block group bitmap allocator
// Action and status codes, bitmap geometry, controller/datapath interface.
// ----------------------------------------------------------------------------
package bgba_pkg;

  localparam int NUM_GROUPS           = 16;
  localparam int MAX_BLOCKS_PER_GROUP = 8192;
  localparam int MAX_LIST             = 64;
  localparam int WORD_W               = 64;
  localparam int BIT_W                = $clog2(WORD_W);
  localparam int GRP_W                = $clog2(NUM_GROUPS);
  localparam int WPG_W                = $clog2(MAX_BLOCKS_PER_GROUP / WORD_W);
  localparam int ADDR_W               = GRP_W + WPG_W;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CLAIM   = 2'd2;
  localparam logic [1:0] ACT_LIST    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_FREE    = 3'd2;
  localparam logic [2:0] ST_USED    = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam logic REG_BPG = 1'b0;
  localparam logic REG_NG  = 1'b1;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic div_step;
    logic rd_rmw;
    logic rmw_do;
    logic alloc_take;
    logic adv;
    logic set_nospace;
    logic load_mask;
    logic list_emit;
    logic fin_emit;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_done;
    logic in_range;
    logic in_search;
    logic div_more;
    logic free_any;
    logic is_list;
    logic last_word;
    logic last_group;
    logic mask_more;
    logic want_one;
    logic out_ready;
  } sts_t;

  // index of the lowest set bit
  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) r = BIT_W'(k);
    end
    return r;
  endfunction

endpackage

/* rtl/core/block_group_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// block_group_bitmap_allocator: grouped free-block bitmap allocator
// Allocate, release, claim and list blocks over a word-wide bitmap memory.
// ----------------------------------------------------------------------------
//   channel | ports                          | contents
//   --------+--------------------------------+---------------------------------
//   input   | in_tvalid/in_tready            | tuser: action; tdata: block, count
//   result  | out_tvalid/out_tready/out_tlast| tdata: block, status, free total
//   config  | cfg_wr_en/cfg_index/cfg_wdata  | 0 blocks per group, 1 groups
//
// After reset and after each config write a clear sweep runs over all 2048
// words of the bitmap memory; no item is taken meanwhile. Allocate and list
// scan one 64-bit word at a time (one memory read port); list issues one
// result per reported block. Release and claim find the group by repeated
// subtraction of the group size, then read and update the addressed bit.
// A stalled result register holds the sequencer; one item is in work at a time.
// ----------------------------------------------------------------------------
module block_group_bitmap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [31:0] in_tdata,   // [17:0] block_number, [24:18] wanted_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [17:0] block_number_res, [20:18] status,
                                  // [38:21] free_total
  output logic        out_tlast
);
  import bgba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bgba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bgba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/core/bgba_dp.sv */
// ----------------------------------------------------------------------------
// bgba_dp: allocator datapath
// Bitmap memory, config registers, free counter, scan pointers, result reg.
// ----------------------------------------------------------------------------
module bgba_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [13:0]         cfg_wdata,
  input  logic [1:0]          in_tuser,
  input  logic [31:0]         in_tdata,
  input  bgba_pkg::cmd_t      cmd,
  output bgba_pkg::sts_t      sts,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [39:0]         out_tdata,
  output logic                out_tlast
);
  import bgba_pkg::*;

  logic [WORD_W-1:0] mem [1 << ADDR_W];
  logic [WORD_W-1:0] rdata_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [13:0]       bpg_r;
  logic [4:0]        ng_r;
  logic [17:0]       total_r, total_nxt;
  logic [1:0]        act_r;
  logic [6:0]        want_r;
  logic [16:0]       rem_r;
  logic [4:0]        g_r;
  logic [WPG_W-1:0]  w_r;
  logic [17:0]       gbase_r;
  logic [WORD_W-1:0] mask_r;
  logic [2:0]        fin_st_r;
  logic              out_valid_r;
  logic [17:0]       out_blk_r, out_blk_nxt;
  logic [2:0]        out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;
  logic [17:0]       out_free_r;

  logic [13:0]       bpg8, eff_bpg;
  logic [4:0]        eff_ng;
  logic [18:0]       cap;
  logic [17:0]       in_blk;
  logic [6:0]        in_want, want0;
  logic [7:0]        nw;
  logic [13:0]       n_valid;
  logic [WORD_W-1:0] vmask, free_w, mask_less;
  logic [BIT_W-1:0]  first_free, first_mask;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              wr_en, bit_set, rmw_ok, emit;

  always_comb begin
    bpg8 = {bpg_r[13:3], 3'b000};
    if (bpg8 < 14'd8) eff_bpg = 14'd8;
    else if (bpg8 > 14'(MAX_BLOCKS_PER_GROUP)) eff_bpg = 14'(MAX_BLOCKS_PER_GROUP);
    else eff_bpg = bpg8;
    if (ng_r == 5'd0) eff_ng = 5'd1;
    else if (ng_r > 5'(NUM_GROUPS)) eff_ng = 5'(NUM_GROUPS);
    else eff_ng = ng_r;
    cap = 19'(eff_bpg * eff_ng);
  end

  assign in_blk  = in_tdata[17:0];
  assign in_want = in_tdata[24:18];
  assign want0   = (in_want == 7'd0) ? 7'd1 :
                   (in_want > 7'(MAX_LIST)) ? 7'(MAX_LIST) : in_want;

  // words per group, and the valid bits of the current word
  assign nw      = 8'((15'(eff_bpg) + 15'd63) >> BIT_W);
  assign n_valid = eff_bpg - 14'({w_r, {BIT_W{1'b0}}});
  assign vmask   = (n_valid >= 14'(WORD_W)) ? '1 :
                   ((WORD_W'(1) << n_valid[BIT_W-1:0]) - WORD_W'(1));
  assign free_w     = ~rdata_r & vmask;
  assign mask_less  = mask_r & (mask_r - WORD_W'(1));
  assign first_free = low_bit(free_w);
  assign first_mask = low_bit(mask_r);

  assign bit_set = rdata_r[rem_r[BIT_W-1:0]];
  assign rmw_ok  = (act_r == ACT_RELEASE) ? bit_set : !bit_set;

  assign rd_addr = cmd.rd_rmw ? {g_r[GRP_W-1:0], rem_r[BIT_W+WPG_W-1:BIT_W]}
                              : {g_r[GRP_W-1:0], w_r};
  assign wr_addr = cmd.clr_step ? clr_addr_r : rd_addr;
  assign wr_en   = cmd.clr_step | (cmd.rmw_do & rmw_ok) | cmd.alloc_take;
  always_comb begin
    if (cmd.clr_step) wr_data = '0;
    else if (cmd.alloc_take) wr_data = rdata_r | (WORD_W'(1) << first_free);
    else wr_data = rdata_r ^ (WORD_W'(1) << rem_r[BIT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.clr_step) total_nxt = cap[17:0];
    else if (cmd.rmw_do && rmw_ok) begin
      total_nxt = (act_r == ACT_RELEASE) ? total_r + 18'd1 : total_r - 18'd1;
    end else if (cmd.alloc_take) total_nxt = total_r - 18'd1;
  end

  always_comb begin
    out_blk_nxt  = '0;
    out_st_nxt   = ST_OK;
    out_last_nxt = 1'b1;
    if (cmd.rmw_do) begin
      if (!rmw_ok) out_st_nxt = (act_r == ACT_RELEASE) ? ST_FREE : ST_USED;
    end else if (cmd.alloc_take) begin
      out_blk_nxt = gbase_r + 18'({w_r, first_free}) + 18'd1;
    end else if (cmd.list_emit) begin
      out_blk_nxt  = gbase_r + 18'({w_r, first_mask}) + 18'd1;
      out_last_nxt = (want_r == 7'd1);
    end else begin
      out_st_nxt = fin_st_r;
    end
  end

  assign emit = cmd.rmw_do | cmd.alloc_take | cmd.list_emit | cmd.fin_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpg_r       <= 14'(MAX_BLOCKS_PER_GROUP);
      ng_r        <= 5'(NUM_GROUPS);
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_BPG) bpg_r <= cfg_wdata;
        else ng_r <= cfg_wdata[4:0];
        clr_addr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    if (emit) begin
      out_blk_r  <= out_blk_nxt;
      out_st_r   <= out_st_nxt;
      out_last_r <= out_last_nxt;
      out_free_r <= total_nxt;
    end
    if (cmd.accept) begin
      act_r    <= in_tuser;
      rem_r    <= 17'(in_blk - 18'd1);
      want_r   <= want0;
      g_r      <= '0;
      w_r      <= '0;
      gbase_r  <= '0;
      fin_st_r <= ST_RANGE;
    end else begin
      if (cmd.div_step) begin
        rem_r <= rem_r - 17'(eff_bpg);
        g_r   <= g_r + 5'd1;
      end
      if (cmd.adv) begin
        if (sts.last_word) begin
          g_r     <= g_r + 5'd1;
          w_r     <= '0;
          gbase_r <= gbase_r + 18'(eff_bpg);
        end else begin
          w_r <= w_r + WPG_W'(1);
        end
      end
      if (cmd.set_nospace) fin_st_r <= ST_NOSPACE;
      if (cmd.load_mask) mask_r <= free_w;
      if (cmd.list_emit) begin
        mask_r <= mask_less;
        want_r <= want_r - 7'd1;
      end
    end
  end

  always_comb begin
    sts.cfg_hit    = cfg_wr_en;
    sts.clr_done   = (clr_addr_r == '1);
    sts.in_range   = (in_blk != 18'd0) && (19'(in_blk - 18'd1) < cap);
    sts.in_search  = (in_tuser == ACT_ALLOC) || (in_tuser == ACT_LIST);
    sts.div_more   = rem_r >= 17'(eff_bpg);
    sts.free_any   = (free_w != '0);
    sts.is_list    = (act_r == ACT_LIST);
    sts.last_word  = ({1'b0, w_r} == nw - 8'd1);
    sts.last_group = (g_r == eff_ng - 5'd1);
    sts.mask_more  = (mask_less != '0);
    sts.want_one   = (want_r == 7'd1);
    sts.out_ready  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_st_r, out_blk_r};
  assign out_tlast  = out_last_r;

  a_rmw_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rmw_do |-> (rem_r < 17'(eff_bpg)))
    else $error("bit update before group split finished");
  a_list_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.list_emit |-> (mask_r != '0))
    else $error("list result with empty free mask");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=>
      (out_valid_r && $stable(out_tdata) && $stable(out_tlast)))
    else $error("result changed while waiting for transfer");

endmodule

/* rtl/core/bgba_ctrl.sv */
// ----------------------------------------------------------------------------
// bgba_ctrl: allocator controller
// Sequences clear sweep, group split, bit update, word scan and result issue.
// ----------------------------------------------------------------------------
module bgba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  bgba_pkg::sts_t sts,
  output bgba_pkg::cmd_t cmd
);
  import bgba_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_RRD   = 4'd3;
  localparam logic [3:0] S_RCHK  = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCHK  = 4'd6;
  localparam logic [3:0] S_LIST  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.in_search) state_nxt = S_SRD;
          else if (sts.in_range) state_nxt = S_DIV;
          else state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        if (sts.div_more) cmd.div_step = 1'b1;
        else state_nxt = S_RRD;
      end
      S_RRD: begin
        cmd.rd_rmw = 1'b1;
        state_nxt  = S_RCHK;
      end
      S_RCHK: begin
        cmd.rd_rmw = 1'b1;
        if (sts.out_ready) begin
          cmd.rmw_do = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        if (sts.free_any) begin
          if (sts.is_list) begin
            cmd.load_mask = 1'b1;
            state_nxt     = S_LIST;
          end else if (sts.out_ready) begin
            cmd.alloc_take = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (sts.last_word && sts.last_group) begin
          cmd.set_nospace = 1'b1;
          state_nxt       = S_FIN;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_LIST: begin
        if (sts.out_ready) begin
          cmd.list_emit = 1'b1;
          if (sts.want_one) state_nxt = S_IDLE;
          else if (!sts.mask_more) begin
            if (sts.last_word && sts.last_group) begin
              cmd.set_nospace = 1'b1;
              state_nxt       = S_FIN;
            end else begin
              cmd.adv   = 1'b1;
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_FIN: begin
        if (sts.out_ready) begin
          cmd.fin_emit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // new geometry: wipe the bitmap again
    if (sts.cfg_hit) state_nxt = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rmw_do || cmd.alloc_take || cmd.list_emit || cmd.fin_emit) |-> sts.out_ready)
    else $error("result issued while output register full");
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.in_search && !sts.cfg_hit) |=> (state_r == S_SRD))
    else $error("search did not start after transfer");
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input ready during clear sweep");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the block group bitmap allocator
// Predicts every result from a bit-level copy of the allocation map and the
// free counts, and checks each result transfer in order. Covers directed
// corner cases, then random allocate/release/claim/list traffic over small
// and large geometries, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import bgba_pkg::*;

  localparam int MAP_BITS   = NUM_GROUPS * MAX_BLOCKS_PER_GROUP;
  localparam int STALL_MAX  = 30000;

  typedef struct packed {
    logic [17:0] blk;
    logic [2:0]  st;
    logic        last;
    logic [17:0] free;
  } alloc_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [13:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  block_group_bitmap_allocator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // shadow allocator state
  bit          used_map [MAP_BITS];
  logic [13:0] bpg_reg;
  logic [4:0]  ng_reg;
  int          bpg_eff;
  int          ng_eff;
  logic [17:0] free_total;

  alloc_res_t  pending_q [$];
  int          err_cnt = 0;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          stall_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reformat();
    bpg_eff = int'(bpg_reg) & ~7;
    if (bpg_eff < 8) bpg_eff = 8;
    if (bpg_eff > MAX_BLOCKS_PER_GROUP) bpg_eff = MAX_BLOCKS_PER_GROUP;
    ng_eff = int'(ng_reg);
    if (ng_eff < 1) ng_eff = 1;
    if (ng_eff > NUM_GROUPS) ng_eff = NUM_GROUPS;
    foreach (used_map[k]) used_map[k] = 1'b0;
    free_total = 18'(bpg_eff * ng_eff);
  endfunction

  function automatic void push_res(int blk, logic [2:0] st, logic last);
    alloc_res_t r;
    r.blk  = 18'(blk);
    r.st   = st;
    r.last = last;
    r.free = free_total;
    pending_q.push_back(r);
  endfunction

  // expected results of one accepted item
  function automatic void predict_alloc(logic [1:0] act, logic [17:0] blk, logic [6:0] want);
    int n;
    int wanted;
    int off;
    int pos;
    n = 0;
    if (act == ACT_ALLOC) begin
      for (int g = 0; g < ng_eff; g++)
        for (int i = 0; i < bpg_eff; i++)
          if (n == 0 && !used_map[g * MAX_BLOCKS_PER_GROUP + i]) begin
            used_map[g * MAX_BLOCKS_PER_GROUP + i] = 1'b1;
            free_total = free_total - 18'd1;
            push_res(g * bpg_eff + i + 1, ST_OK, 1'b1);
            n = 1;
          end
      if (n == 0) push_res(0, ST_NOSPACE, 1'b1);
    end else if (act == ACT_LIST) begin
      wanted = int'(want);
      if (wanted < 1) wanted = 1;
      if (wanted > MAX_LIST) wanted = MAX_LIST;
      for (int g = 0; g < ng_eff; g++)
        for (int i = 0; i < bpg_eff; i++)
          if (n < wanted && !used_map[g * MAX_BLOCKS_PER_GROUP + i]) begin
            n++;
            push_res(g * bpg_eff + i + 1, ST_OK, n == wanted);
          end
      if (n < wanted) push_res(0, ST_NOSPACE, 1'b1);
    end else if (blk == 18'd0 || int'(blk) - 1 >= bpg_eff * ng_eff) begin
      push_res(0, ST_RANGE, 1'b1);
    end else begin
      off = int'(blk) - 1;
      pos = (off / bpg_eff) * MAX_BLOCKS_PER_GROUP + off % bpg_eff;
      if (act == ACT_RELEASE) begin
        if (!used_map[pos]) push_res(0, ST_FREE, 1'b1);
        else begin
          used_map[pos] = 1'b0;
          free_total = free_total + 18'd1;
          push_res(0, ST_OK, 1'b1);
        end
      end else begin
        if (used_map[pos]) push_res(0, ST_USED, 1'b1);
        else begin
          used_map[pos] = 1'b1;
          free_total = free_total - 18'd1;
          push_res(0, ST_OK, 1'b1);
        end
      end
    end
  endfunction

  task automatic send_item(logic [1:0] act, logic [17:0] blk, logic [6:0] want);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, want, blk};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_alloc(act, blk, want);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [13:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_BPG) bpg_reg = val;
    else ng_reg = val[4:0];
    reformat();
  endtask

  task automatic test_default_geometry();
    send_item(ACT_ALLOC, 18'd0, 7'd0);
    send_item(ACT_LIST, 18'd0, 7'd64);
    send_item(ACT_CLAIM, 18'd131072, 7'd0);
    send_item(ACT_CLAIM, 18'd131072, 7'd0);
    send_item(ACT_RELEASE, 18'd131072, 7'd0);
    send_item(ACT_RELEASE, 18'd131072, 7'd0);
    send_item(ACT_CLAIM, 18'd131073, 7'd0);
    send_item(ACT_RELEASE, 18'd0, 7'd0);
    send_item(ACT_RELEASE, 18'h3FFFF, 7'd0);
    send_item(ACT_RELEASE, 18'd1, 7'd0);
    send_item(ACT_LIST, 18'h3FFFF, 7'd0);
    send_item(ACT_LIST, 18'd0, 7'h7F);
  endtask

  task automatic test_tiny_geometry();
    write_reg(REG_NG, 14'd0);    // held up to one group
    write_reg(REG_BPG, 14'd5);   // rounds to zero, held up to eight
    for (int k = 0; k < 9; k++) send_item(ACT_ALLOC, 18'd0, 7'd0);
    send_item(ACT_LIST, 18'd0, 7'd3);
    send_item(ACT_RELEASE, 18'd3, 7'd0);
    send_item(ACT_RELEASE, 18'd8, 7'd0);
    send_item(ACT_LIST, 18'd0, 7'd5);
    send_item(ACT_CLAIM, 18'd9, 7'd0);
    write_reg(REG_BPG, 14'h3FFF); // held down to the maximum
    write_reg(REG_NG, 14'h3FFF);  // low five bits, held to the group count
    send_item(ACT_CLAIM, 18'd131072, 7'd0);
  endtask

  task automatic random_phase(int items, logic [13:0] bpg, logic [4:0] ng);
    int sel;
    int span;
    logic [17:0] blk;
    logic [6:0]  want;
    write_reg(REG_BPG, bpg);
    write_reg(REG_NG, {9'd0, ng});
    span = bpg_eff * ng_eff;
    for (int k = 0; k < items; k++) begin
      sel  = $urandom_range(99);
      blk  = ($urandom_range(99) < 85) ? 18'($urandom_range(span, 1)) : 18'($urandom);
      want = ($urandom_range(99) < 80) ? 7'($urandom_range(12, 1)) : 7'($urandom);
      if (sel < 40)      send_item(ACT_ALLOC, 18'($urandom), 7'($urandom));
      else if (sel < 65) send_item(ACT_RELEASE, blk, want);
      else if (sel < 85) send_item(ACT_CLAIM, blk, want);
      else               send_item(ACT_LIST, blk, want);
    end
  endtask

  task automatic test_random_traffic();
    random_phase(40, 14'd16, 5'd2);
    random_phase(30, 14'd8, 5'd3);
    random_phase(20, 14'd64, 5'd1);
    random_phase(10, 14'd8192, 5'd16);
  endtask

  // result checker
  always @(posedge clk) begin
    alloc_res_t want_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: tdata=%h", out_tdata);
        err_cnt++;
      end else begin
        want_r = pending_q.pop_front();
        if (out_tdata[17:0] !== want_r.blk) begin
          $error("block_number_res exp %0d got %0d", want_r.blk, out_tdata[17:0]);
          err_cnt++;
        end
        if (out_tdata[20:18] !== want_r.st) begin
          $error("status exp %0d got %0d", want_r.st, out_tdata[20:18]);
          err_cnt++;
        end
        if (out_tlast !== want_r.last) begin
          $error("last exp %0d got %0d", want_r.last, out_tlast);
          err_cnt++;
        end
        if (out_tdata[38:21] !== want_r.free) begin
          $error("free_total exp %0d got %0d", want_r.free, out_tdata[38:21]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else if (stall_cnt >= STALL_MAX) begin
      $display("== FAIL ==");
      $finish;
    end else stall_cnt <= stall_cnt + 1;
  end

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = 1'b0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tuser     = '0;
    in_tdata     = '0;
    snd_idle_pct = 27;
    rcv_idle_pct = 61;
    bpg_reg      = 14'd8192;
    ng_reg       = 5'd16;
    reformat();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_geometry();
    test_tiny_geometry();
    test_random_traffic();
    snd_idle_pct = 61;
    rcv_idle_pct = 27;
    test_random_traffic();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_traffic();
    drain();

    if (err_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
